[design/stpt_pkg.sv]
`timescale 1ns / 1ps

package stpt_pkg;

    localparam int PATH_DEPTH_DEF   = 1024;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MUL_STEPS        = 32;

    localparam int IDX_W       = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int POINT_W     = 80;

    localparam logic [CFG_INDEX_W-1:0] CFG_CROSS_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHEELBASE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_SPEED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEER_LIMIT  = 3'd4;

    localparam logic [15:0] CROSS_GAIN_RST   = 16'd128;
    localparam logic [15:0] SPEED_GAIN_RST   = 16'd2560;
    localparam logic [20:0] WHEELBASE_RST    = 21'd21299;
    localparam logic [14:0] CRUISE_SPEED_RST = 15'd128;
    localparam logic [13:0] STEER_LIMIT_RST  = 14'd3431;

    localparam logic signed [16:0] PI_Q13     = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
    localparam logic signed [34:0] PI_R30     = 35'sd3373259426;
    localparam logic signed [34:0] HALF_R30   = 35'sd1686629713;
    localparam logic signed [56:0] CORDIC_X0  = 57'sd163008218;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT_INIT,
        ST_ROT,
        ST_TRIG,
        ST_AXLE_MUL,
        ST_AXLE_ADD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_TGT_RD,
        ST_TGT_WAIT,
        ST_MUL_INIT,
        ST_MUL_RUN,
        ST_MUL_TAKE,
        ST_ERR,
        ST_MONO,
        ST_VEC_INIT,
        ST_VEC,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_XS,
        MUL_YC,
        MUL_KE
    } mul_sel_t;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       rot_init;
        logic       vec_init;
        logic       cordic_step;
        logic [4:0] shift;
        logic       trig_take;
        logic       axle_mul;
        logic       axle_add;
        logic       scan_init;
        logic       tgt_read;
        logic       diff_take;
        logic       mul_init;
        logic       mul_step;
        logic       mul_take;
        mul_sel_t   sel;
        logic       err_calc;
        logic       mono;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic loaded;
        logic scan_done;
        logic stopped;
    } status_t;

    function automatic logic [31:0] atan_r30(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h3243F6A8;
            5'd1:    a = 32'h1DAC6705;
            5'd2:    a = 32'h0FADBAFC;
            5'd3:    a = 32'h07F56EA6;
            5'd4:    a = 32'h03FEAB76;
            5'd5:    a = 32'h01FFD55B;
            5'd6:    a = 32'h00FFFAAA;
            5'd7:    a = 32'h007FFF55;
            5'd8:    a = 32'h003FFFEA;
            5'd9:    a = 32'h001FFFFD;
            5'd10:   a = 32'h000FFFFF;
            5'd11:   a = 32'h0007FFFF;
            5'd12:   a = 32'h0003FFFF;
            5'd13:   a = 32'h0001FFFF;
            5'd14:   a = 32'h0000FFFF;
            5'd15:   a = 32'h00007FFF;
            5'd16:   a = 32'h00003FFF;
            5'd17:   a = 32'h00001FFF;
            5'd18:   a = 32'h00000FFF;
            5'd19:   a = 32'h000007FF;
            5'd20:   a = 32'h000003FF;
            5'd21:   a = 32'h000001FF;
            5'd22:   a = 32'h000000FF;
            5'd23:   a = 32'h0000007F;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

[design/stpt_ram.sv]
`timescale 1ns / 1ps

module stpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/stpt_ctrl.sv]
`timescale 1ns / 1ps

module stpt_ctrl #(
    parameter int CORDIC_STEPS = stpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_func,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  stpt_pkg::status_t status,
    output stpt_pkg::cmd_t    cmd
);

    stpt_pkg::state_t   state_reg, state_next;
    stpt_pkg::mul_sel_t sel_reg, sel_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               rot_last, mul_last;

    assign out_free = !out_valid_reg || m_tready;
    assign rot_last = (cnt_reg == 6'(CORDIC_STEPS - 1));
    assign mul_last = (cnt_reg == 6'(stpt_pkg::MUL_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            stpt_pkg::ST_IDLE: begin
                if (s_tvalid && in_func && status.loaded) begin
                    state_next = stpt_pkg::ST_ROT_INIT;
                end
            end
            stpt_pkg::ST_ROT_INIT: begin
                cnt_next   = '0;
                state_next = stpt_pkg::ST_ROT;
            end
            stpt_pkg::ST_ROT: begin
                cnt_next = cnt_reg + 6'd1;
                if (rot_last) begin
                    state_next = stpt_pkg::ST_TRIG;
                end
            end
            stpt_pkg::ST_TRIG:      state_next = stpt_pkg::ST_AXLE_MUL;
            stpt_pkg::ST_AXLE_MUL:  state_next = stpt_pkg::ST_AXLE_ADD;
            stpt_pkg::ST_AXLE_ADD:  state_next = stpt_pkg::ST_SCAN_INIT;
            stpt_pkg::ST_SCAN_INIT: state_next = stpt_pkg::ST_SCAN;
            stpt_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = stpt_pkg::ST_TGT_RD;
                end
            end
            stpt_pkg::ST_TGT_RD: state_next = stpt_pkg::ST_TGT_WAIT;
            stpt_pkg::ST_TGT_WAIT: begin
                sel_next   = stpt_pkg::MUL_XS;
                state_next = stpt_pkg::ST_MUL_INIT;
            end
            stpt_pkg::ST_MUL_INIT: begin
                cnt_next   = '0;
                state_next = stpt_pkg::ST_MUL_RUN;
            end
            stpt_pkg::ST_MUL_RUN: begin
                cnt_next = cnt_reg + 6'd1;
                if (mul_last) begin
                    state_next = stpt_pkg::ST_MUL_TAKE;
                end
            end
            stpt_pkg::ST_MUL_TAKE: begin
                unique case (sel_reg)
                    stpt_pkg::MUL_XS: begin
                        sel_next   = stpt_pkg::MUL_YC;
                        state_next = stpt_pkg::ST_MUL_INIT;
                    end
                    stpt_pkg::MUL_YC: state_next = stpt_pkg::ST_ERR;
                    default:          state_next = stpt_pkg::ST_MONO;
                endcase
            end
            stpt_pkg::ST_ERR: begin
                sel_next   = stpt_pkg::MUL_KE;
                state_next = stpt_pkg::ST_MUL_INIT;
            end
            stpt_pkg::ST_MONO: state_next = stpt_pkg::ST_VEC_INIT;
            stpt_pkg::ST_VEC_INIT: begin
                cnt_next   = '0;
                state_next = stpt_pkg::ST_VEC;
            end
            stpt_pkg::ST_VEC: begin
                cnt_next = cnt_reg + 6'd1;
                if (rot_last) begin
                    state_next = stpt_pkg::ST_FINISH;
                end
            end
            stpt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = stpt_pkg::ST_IDLE;
                end
            end
            default: state_next = stpt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.shift      = cnt_reg[4:0];
        cmd.sel        = sel_reg;
        s_tready       = (state_reg == stpt_pkg::ST_IDLE);
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            stpt_pkg::ST_IDLE: begin
                cmd.load    = s_tvalid && !in_func;
                cmd.capture = s_tvalid && in_func;
            end
            stpt_pkg::ST_ROT_INIT:  cmd.rot_init    = 1'b1;
            stpt_pkg::ST_ROT:       cmd.cordic_step = 1'b1;
            stpt_pkg::ST_TRIG:      cmd.trig_take   = 1'b1;
            stpt_pkg::ST_AXLE_MUL:  cmd.axle_mul    = 1'b1;
            stpt_pkg::ST_AXLE_ADD:  cmd.axle_add    = 1'b1;
            stpt_pkg::ST_SCAN_INIT: cmd.scan_init   = 1'b1;
            stpt_pkg::ST_TGT_RD:    cmd.tgt_read    = 1'b1;
            stpt_pkg::ST_TGT_WAIT:  cmd.diff_take   = 1'b1;
            stpt_pkg::ST_MUL_INIT:  cmd.mul_init    = 1'b1;
            stpt_pkg::ST_MUL_RUN:   cmd.mul_step    = 1'b1;
            stpt_pkg::ST_MUL_TAKE:  cmd.mul_take    = 1'b1;
            stpt_pkg::ST_ERR:       cmd.err_calc    = 1'b1;
            stpt_pkg::ST_MONO:      cmd.mono        = 1'b1;
            stpt_pkg::ST_VEC_INIT:  cmd.vec_init    = 1'b1;
            stpt_pkg::ST_VEC:       cmd.cordic_step = 1'b1;
            stpt_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stpt_pkg::ST_IDLE;
            sel_reg       <= stpt_pkg::MUL_XS;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[design/stpt_dp.sv]
`timescale 1ns / 1ps

module stpt_dp #(
    parameter int PATH_DEPTH = stpt_pkg::PATH_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [stpt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [stpt_pkg::IDX_W-1:0]          in_point_index,
    input  logic                                in_last_point,
    input  logic signed [31:0]                  in_pos_x,
    input  logic signed [31:0]                  in_pos_y,
    input  logic signed [15:0]                  in_heading,
    input  logic signed [15:0]                  in_speed,
    input  logic [15:0]                         in_step_time,
    input  stpt_pkg::cmd_t                      cmd,
    output stpt_pkg::status_t                   status,
    output logic signed [15:0]                  out_speed_cmd,
    output logic signed [14:0]                  out_steer_cmd,
    output logic [stpt_pkg::IDX_W-1:0]          out_target_index,
    output logic                                out_stopped
);

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int IW = stpt_pkg::IDX_W;

    logic [15:0] gain_reg, kp_reg;
    logic [20:0] wb_reg;
    logic [14:0] cruise_reg;
    logic [13:0] lim_reg;

    logic [IW-1:0] end_reg, prev_reg, tgt_reg, tgtm_reg;
    logic          loaded_reg, prev_valid_reg, stop_reg;

    logic signed [31:0] x_in_reg, y_in_reg;
    logic signed [15:0] yaw_reg, v_reg;
    logic [15:0]        dt_reg;

    logic signed [56:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               vec_mode_reg, neg_reg, zero_reg;
    logic signed [31:0] c_reg, s_reg;

    logic signed [34:0] p1_reg;
    logic signed [51:0] p2_reg;
    logic signed [15:0] spd_reg;
    logic signed [53:0] pwx_reg, pwy_reg;
    logic signed [33:0] fx_reg, fy_reg;

    logic          issue_reg, v1_reg, v2_reg, v3_reg, first_reg;
    logic [IW-1:0] sidx_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]   ax_reg, ay_reg;
    logic [63:0]   sqx_reg, sqy_reg;
    logic [64:0]   best_reg;

    logic signed [34:0] dx_reg, dy_reg;
    logic [69:0]        acc_reg;
    logic [37:0]        mcand_reg;
    logic               mneg_reg;
    logic signed [70:0] pxs_reg, pyc_reg;
    logic signed [56:0] pke_reg;
    logic signed [37:0] err_reg;

    logic [stpt_pkg::POINT_W-1:0] ram_rdata;
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_raddr;
    logic signed [31:0]           ram_x, ram_y;
    logic signed [15:0]           ram_h;

    assign ram_x = ram_rdata[31:0];
    assign ram_y = ram_rdata[63:32];
    assign ram_h = ram_rdata[79:64];

    // Monotonic target and stop decision.
    logic [IW-1:0] tgt_m;
    assign tgt_m = (prev_valid_reg && prev_reg >= tgt_reg) ? prev_reg : tgt_reg;

    assign ram_we = cmd.load && ({22'b0, in_point_index} < 32'(PATH_DEPTH));
    assign ram_re = issue_reg || cmd.tgt_read || cmd.mono;

    always_comb begin
        priority if (cmd.tgt_read) begin
            ram_raddr = AW'(tgt_reg);
        end else if (cmd.mono) begin
            ram_raddr = AW'(tgt_m);
        end else begin
            ram_raddr = AW'(sidx_reg);
        end
    end

    stpt_ram #(
        .WIDTH(stpt_pkg::POINT_W),
        .DEPTH(PATH_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(in_point_index)),
        .wdata({in_heading, in_pos_y, in_pos_x}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= stpt_pkg::CROSS_GAIN_RST;
            kp_reg     <= stpt_pkg::SPEED_GAIN_RST;
            wb_reg     <= stpt_pkg::WHEELBASE_RST;
            cruise_reg <= stpt_pkg::CRUISE_SPEED_RST;
            lim_reg    <= stpt_pkg::STEER_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                stpt_pkg::CFG_CROSS_GAIN:   gain_reg   <= cfg_wdata[15:0];
                stpt_pkg::CFG_SPEED_GAIN:   kp_reg     <= cfg_wdata[15:0];
                stpt_pkg::CFG_WHEELBASE:    wb_reg     <= cfg_wdata[20:0];
                stpt_pkg::CFG_CRUISE_SPEED: cruise_reg <= cfg_wdata[14:0];
                stpt_pkg::CFG_STEER_LIMIT:  lim_reg    <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg        <= '0;
            loaded_reg     <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            stop_reg       <= 1'b0;
        end else begin
            if (ram_we) begin
                loaded_reg <= 1'b1;
                if (in_last_point) begin
                    end_reg <= in_point_index;
                end
            end
            if (cmd.mono && prev_valid_reg && tgt_m == end_reg && tgt_m == prev_reg) begin
                stop_reg <= 1'b1;
            end
            if (cmd.finish) begin
                prev_reg       <= tgtm_reg;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_in_reg <= in_pos_x;
            y_in_reg <= in_pos_y;
            yaw_reg  <= in_heading;
            v_reg    <= in_speed;
            dt_reg   <= in_step_time;
        end
    end

    // Shared CORDIC: rotation for the yaw, vectoring for the steer correction.
    logic signed [34:0] z0;
    logic signed [56:0] xs, ys, vx0;
    logic signed [34:0] at;
    logic               dir;

    assign z0  = {{2{yaw_reg[15]}}, yaw_reg, 17'b0};
    assign vx0 = {{25{v_reg[15]}}, v_reg, 16'b0};
    assign xs  = cx_reg >>> cmd.shift;
    assign ys  = cy_reg >>> cmd.shift;
    assign at  = $signed({3'b0, stpt_pkg::atan_r30(cmd.shift)});
    assign dir = vec_mode_reg ? !cy_reg[56] : !cz_reg[34];

    always_ff @(posedge aclk) begin
        if (cmd.rot_init) begin
            vec_mode_reg <= 1'b0;
            cx_reg       <= stpt_pkg::CORDIC_X0;
            cy_reg       <= '0;
            if (z0 > stpt_pkg::HALF_R30) begin
                cz_reg  <= z0 - stpt_pkg::PI_R30;
                neg_reg <= 1'b1;
            end else if (z0 < -stpt_pkg::HALF_R30) begin
                cz_reg  <= z0 + stpt_pkg::PI_R30;
                neg_reg <= 1'b1;
            end else begin
                cz_reg  <= z0;
                neg_reg <= 1'b0;
            end
        end else if (cmd.vec_init) begin
            vec_mode_reg <= 1'b1;
            zero_reg     <= (v_reg == 16'sd0) && (pke_reg == 57'sd0);
            if (v_reg[15]) begin
                cx_reg <= -vx0;
                cy_reg <= -pke_reg;
                cz_reg <= pke_reg[56] ? -stpt_pkg::PI_R30 : stpt_pkg::PI_R30;
            end else begin
                cx_reg <= vx0;
                cy_reg <= pke_reg;
                cz_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            if (dir) begin
                cx_reg <= vec_mode_reg ? cx_reg + ys : cx_reg - ys;
                cy_reg <= vec_mode_reg ? cy_reg - xs : cy_reg + xs;
                cz_reg <= vec_mode_reg ? cz_reg + at : cz_reg - at;
            end else begin
                cx_reg <= vec_mode_reg ? cx_reg - ys : cx_reg + ys;
                cy_reg <= vec_mode_reg ? cy_reg + xs : cy_reg - xs;
                cz_reg <= vec_mode_reg ? cz_reg - at : cz_reg + at;
            end
        end
    end

    // Front axle and speed command.
    logic signed [17:0] vdiff;
    logic signed [27:0] spd_step;
    logic signed [28:0] spd_sum;

    assign vdiff    = $signed({3'b0, cruise_reg}) - 18'(v_reg);
    assign spd_step = 28'((p2_reg + 52'sd8388608) >>> 24);
    assign spd_sum  = 29'(v_reg) + 29'(spd_step);

    always_ff @(posedge aclk) begin
        if (cmd.trig_take) begin
            c_reg  <= neg_reg ? -cx_reg[31:0] : cx_reg[31:0];
            s_reg  <= neg_reg ? -cy_reg[31:0] : cy_reg[31:0];
            p1_reg <= $signed({1'b0, kp_reg}) * vdiff;
        end
        if (cmd.axle_mul) begin
            pwx_reg <= $signed({1'b0, wb_reg}) * c_reg;
            pwy_reg <= $signed({1'b0, wb_reg}) * s_reg;
            p2_reg  <= p1_reg * $signed({1'b0, dt_reg});
        end
        if (cmd.axle_add) begin
            fx_reg <= 34'(x_in_reg) + 34'(pwx_reg >>> 28);
            fy_reg <= 34'(y_in_reg) + 34'(pwy_reg >>> 28);
            if (spd_sum > 29'sd32767) begin
                spd_reg <= 16'sh7FFF;
            end else if (spd_sum < -29'sd32768) begin
                spd_reg <= 16'sh8000;
            end else begin
                spd_reg <= spd_sum[15:0];
            end
        end
    end

    // Nearest point scan: read, distance, square, compare.
    logic signed [34:0] sdx, sdy;
    logic [31:0]        sax, say;
    logic [64:0]        dsq;

    assign sdx  = 35'(fx_reg) - 35'(ram_x);
    assign sdy  = 35'(fy_reg) - 35'(ram_y);
    assign sax  = (sdx > 35'sd2147483648 || sdx < -35'sd2147483648) ? 32'h8000_0000
                : (sdx[34] ? 32'(-sdx) : sdx[31:0]);
    assign say  = (sdy > 35'sd2147483648 || sdy < -35'sd2147483648) ? 32'h8000_0000
                : (sdy[34] ? 32'(-sdy) : sdy[31:0]);
    assign dsq  = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                issue_reg <= 1'b1;
            end else if (issue_reg && sidx_reg == end_reg) begin
                issue_reg <= 1'b0;
            end
            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            sidx_reg  <= '0;
            first_reg <= 1'b1;
        end else begin
            if (issue_reg) begin
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (v3_reg && (first_reg || dsq < best_reg)) begin
                best_reg  <= dsq;
                tgt_reg   <= idx3_reg;
                first_reg <= 1'b0;
            end
        end
        idx1_reg <= sidx_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= sax;
        ay_reg   <= say;
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
    end

    // Serial shift-add multiplier on magnitudes.
    logic signed [37:0] mul_a;
    logic signed [31:0] mul_b;
    logic [38:0]        acc_hi;
    logic signed [70:0] mul_prod;
    logic signed [71:0] err_diff;

    always_comb begin
        unique case (cmd.sel)
            stpt_pkg::MUL_XS: begin
                mul_a = 38'(dx_reg);
                mul_b = s_reg;
            end
            stpt_pkg::MUL_YC: begin
                mul_a = 38'(dy_reg);
                mul_b = c_reg;
            end
            default: begin
                mul_a = err_reg;
                mul_b = $signed({16'b0, gain_reg});
            end
        endcase
    end

    assign acc_hi   = {1'b0, acc_reg[69:32]} + (acc_reg[0] ? {1'b0, mcand_reg} : 39'd0);
    assign mul_prod = mneg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign err_diff = 72'(pxs_reg) - 72'(pyc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.diff_take) begin
            dx_reg <= sdx;
            dy_reg <= sdy;
        end
        if (cmd.mul_init) begin
            mcand_reg <= mul_a[37] ? 38'(-mul_a) : mul_a;
            acc_reg   <= {38'b0, (mul_b[31] ? 32'(-mul_b) : mul_b)};
            mneg_reg  <= mul_a[37] ^ mul_b[31];
        end else if (cmd.mul_step) begin
            acc_reg <= {acc_hi, acc_reg[31:1]};
        end
        if (cmd.mul_take) begin
            unique case (cmd.sel)
                stpt_pkg::MUL_XS: pxs_reg <= mul_prod;
                stpt_pkg::MUL_YC: pyc_reg <= mul_prod;
                default:          pke_reg <= mul_prod[56:0];
            endcase
        end
        if (cmd.err_calc) begin
            err_reg <= 38'(err_diff >>> 28);
        end
        if (cmd.mono) begin
            tgtm_reg <= tgt_m;
        end
    end

    // Steering: wrapped heading error plus cross-track correction, clamped.
    logic signed [16:0] te0, te1;
    logic signed [17:0] td;
    logic signed [18:0] delta, limv;
    logic signed [14:0] steer;

    assign te0   = 17'(ram_h) - 17'(yaw_reg);
    assign te1   = (te0 > stpt_pkg::PI_Q13) ? te0 - stpt_pkg::TWO_PI_Q13
                 : ((te0 <= -stpt_pkg::PI_Q13) ? te0 + stpt_pkg::TWO_PI_Q13 : te0);
    assign td    = zero_reg ? 18'sd0 : 18'((cz_reg + 35'sd65536) >>> 17);
    assign delta = 19'(te1) + 19'(td);
    assign limv  = $signed({5'b0, lim_reg});
    assign steer = (delta > limv) ? limv[14:0] : ((delta < -limv) ? 15'(-limv) : delta[14:0]);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_speed_cmd    <= stop_reg ? 16'sd0 : spd_reg;
            out_steer_cmd    <= stop_reg ? 15'sd0 : steer;
            out_target_index <= tgtm_reg;
            out_stopped      <= stop_reg;
        end
    end

    assign status.loaded    = loaded_reg;
    assign status.scan_done = !issue_reg && !v1_reg && !v2_reg && !v3_reg;
    assign status.stopped   = stop_reg;

endmodule

[design/stanley_path_tracking_steer.sv]
`timescale 1ns / 1ps

// Stanley path-tracking steering and speed controller.
// The input stream carries two kinds of transfer, chosen by s_tuser. A load
// (s_tuser 0) writes one path point into the table; s_tlast marks the end
// point. A control step (s_tuser 1) carries the vehicle pose, speed and step
// time and produces one result on the output stream; loads and control steps
// before any point is loaded produce none.
// A load is written straight into the path memory and leaves the controller
// idle. A control step rotates, scans, reads the target, multiplies and runs
// the vectoring pass, in that order: the scan reads one stored point per cycle
// from the single read port of the path memory, and each CORDIC pass and each
// of three 32-step serial multiplications runs one step per cycle.
// The result sits in an output register, so the next transfer is taken while
// it waits; when the receiver stalls, a second result waits in the finishing
// step until the register frees, and no input is taken meanwhile.
// Configuration writes take effect at once and are meant for idle periods.
// Reset restores the register defaults and empties the table; path memory
// contents are not cleared and no clearing pass is needed.
module stanley_path_tracking_steer #(
    parameter int PATH_DEPTH   = stpt_pkg::PATH_DEPTH_DEF,
    parameter int CORDIC_STEPS = stpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [stpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_index, pos_x, pos_y, heading, speed, step_time, zero fill
    input  logic [127:0]                     s_tdata,
    input  logic                             s_tlast,
    // func
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // speed_cmd, steer_cmd, target_index, zero fill
    output logic [47:0]                      m_tdata,
    // stopped
    output logic [0:0]                       m_tuser
);

    stpt_pkg::cmd_t    cmd;
    stpt_pkg::status_t status;

    logic signed [15:0]         speed_cmd;
    logic signed [14:0]         steer_cmd;
    logic [stpt_pkg::IDX_W-1:0] target_index;
    logic                       stopped;

    stpt_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .in_func (s_tuser[0]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    stpt_dp #(
        .PATH_DEPTH(PATH_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_point_index  (s_tdata[9:0]),
        .in_last_point   (s_tlast),
        .in_pos_x        (s_tdata[41:10]),
        .in_pos_y        (s_tdata[73:42]),
        .in_heading      (s_tdata[89:74]),
        .in_speed        (s_tdata[105:90]),
        .in_step_time    (s_tdata[121:106]),
        .cmd             (cmd),
        .status          (status),
        .out_speed_cmd   (speed_cmd),
        .out_steer_cmd   (steer_cmd),
        .out_target_index(target_index),
        .out_stopped     (stopped)
    );

    assign m_tdata = {7'b0, target_index, steer_cmd, speed_cmd};
    assign m_tuser = stopped;

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.stopped |=> status.stopped)
        else $error("stop latch cleared without reset");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[30:0] == 31'd0)
        else $error("stopped result carries nonzero commands");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("result appeared without a finished control step");

    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cordic_step || cmd.mul_step || !status.scan_done) |-> !s_tready)
        else $error("input ready while a control step is in progress");

endmodule
